[hdl/rphm_pkg.sv]
// ----------------------------------------------------------------------------
// rphm_pkg
// Shared widths, reset values and codes of the RMS and peak-hold level meter.
// ----------------------------------------------------------------------------
package rphm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int HOLD_BITS_DEF   = 20;

  localparam int KIND_BITS      = 2;
  localparam int COEF_FRAC      = 24;
  localparam int COEF_BITS      = COEF_FRAC + 1;
  localparam int HOLD_CFG_BITS  = 20;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  localparam logic [HOLD_CFG_BITS-1:0] HOLD_SAMPLES_RST      = HOLD_CFG_BITS'(88200);
  localparam logic [COEF_BITS-1:0]     PEAK_RELEASE_COEF_RST = COEF_BITS'(1522);
  localparam logic [COEF_BITS-1:0]     RMS_RELEASE_COEF_RST  = COEF_BITS'(3043);
  localparam logic [COEF_BITS-1:0]     RMS_ATTACK_COEF_RST   = COEF_BITS'(30403);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_CLR_PEAK  = 2'd1,
    KIND_CLR_ALL   = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HOLD_SAMPLES      = 2'd0,
    REG_PEAK_RELEASE_COEF = 2'd1,
    REG_RMS_RELEASE_COEF  = 2'd2,
    REG_RMS_ATTACK_COEF   = 2'd3
  } cfg_reg_t;

endpackage

[hdl/rphm_if.sv]
// ----------------------------------------------------------------------------
// rphm_if
// Valid/ready channels of the level meter: sample beats in, level beats out.
// ----------------------------------------------------------------------------
interface rphm_in_if #(
  parameter int SAMPLE_BITS = rphm_pkg::SAMPLE_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [rphm_pkg::KIND_BITS-1:0]      kind;
  logic signed [SAMPLE_BITS-1:0]       sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface rphm_out_if #(
  parameter int SAMPLE_BITS = rphm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] peak_hold_level;
  logic [SAMPLE_BITS-1:0] rms_level;

  modport source (output valid, output peak, output peak_hold_level, output rms_level,
                  input ready);
  modport sink   (input valid, input peak, input peak_hold_level, input rms_level,
                  output ready);
endinterface

[hdl/rms_peak_hold_meter_core.sv]
// ----------------------------------------------------------------------------
// rms_peak_hold_meter_core
// Fixed-point audio level meter: running peak, peak hold with decay, and RMS
// from a one-pole mean square filter, one result beat per input beat.
// ----------------------------------------------------------------------------
// One beat is processed at a time. A sample beat runs through one shared
// shift-add multiplier, one multiplier bit per cycle (square, then the
// held-peak decay when the held peak decays, then the mean square update),
// then a square root that resolves one result bit per cycle. Clear beats
// and the unused kind skip the multiplier and the square root. The next
// beat is accepted while the previous result still waits in the output
// register.
module rms_peak_hold_meter_core #(
  parameter int SAMPLE_BITS = rphm_pkg::SAMPLE_BITS_DEF,
  parameter int HOLD_BITS   = rphm_pkg::HOLD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rphm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rphm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  rphm_in_if.sink                             in_ch,
  rphm_out_if.source                          out_ch
);
  import rphm_pkg::*;

  localparam int MS_BITS  = 2 * SAMPLE_BITS - 1;
  localparam int MB       = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
  localparam int CNT_BITS = $clog2(MB + 1);
  localparam int RAD_BITS = 2 * SAMPLE_BITS;

  localparam logic [COEF_BITS-1:0] COEF_ONE = {1'b1, {COEF_FRAC{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_END,
    S_DECAY,
    S_MS_SET,
    S_MS,
    S_MS_END,
    S_ROOT,
    S_EMIT
  } state_t;

  function automatic logic [COEF_BITS-1:0] sat_coef(input logic [COEF_BITS-1:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

  state_t                   state_r, state_nxt;
  logic [HOLD_CFG_BITS-1:0] hold_samples_r, hold_samples_nxt;
  logic [COEF_BITS-1:0]     prc_r, prc_nxt;
  logic [COEF_BITS-1:0]     rrc_r, rrc_nxt;
  logic [COEF_BITS-1:0]     rac_r, rac_nxt;

  logic [SAMPLE_BITS-1:0]   peak_max_r, peak_max_nxt;
  logic [SAMPLE_BITS-1:0]   held_r, held_nxt;
  logic [HOLD_BITS-1:0]     hold_cnt_r, hold_cnt_nxt;
  logic [MS_BITS-1:0]       ms_r, ms_nxt;
  logic [SAMPLE_BITS-1:0]   rms_r, rms_nxt;
  logic                     decay_r, decay_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [SAMPLE_BITS-1:0]   mag_r, mag_nxt;
  logic [MS_BITS-1:0]       sq_r, sq_nxt;
  logic                     rise_r, rise_nxt;
  logic [MS_BITS-1:0]       mul_a_r, mul_a_nxt;
  logic [MS_BITS-1:0]       mul_hi_r, mul_hi_nxt;
  logic [MB-1:0]            mul_lo_r, mul_lo_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [RAD_BITS-1:0]      rad_r, rad_nxt;
  logic [SAMPLE_BITS:0]     rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]   root_r, root_nxt;
  logic [SAMPLE_BITS-1:0]   out_peak_r, out_peak_nxt;
  logic [SAMPLE_BITS-1:0]   out_hold_r, out_hold_nxt;
  logic [SAMPLE_BITS-1:0]   out_rms_r, out_rms_nxt;

  logic [SAMPLE_BITS-1:0]   in_raw;
  logic [SAMPLE_BITS-1:0]   in_mag;
  logic [MS_BITS:0]         mul_sum;
  logic [MS_BITS-1:0]       mul_sq;
  logic [MS_BITS-1:0]       mul_scaled;
  logic                     mul_inexact;
  logic [SAMPLE_BITS+2:0]   sqrt_rem_ext;
  logic [SAMPLE_BITS+2:0]   sqrt_trial;
  logic                     sqrt_ge;
  logic [SAMPLE_BITS+2:0]   sqrt_diff;
  logic [SAMPLE_BITS-1:0]   sqrt_root;
  logic [MS_BITS-1:0]       ms_diff;
  logic [MS_BITS-1:0]       ms_upd;
  logic [COEF_BITS-1:0]     ms_coef;
  logic                     sq_above;

  assign in_raw = in_ch.sample;
  assign in_mag = in_raw[SAMPLE_BITS-1] ? (~in_raw + 1'b1) : in_raw;

  assign mul_sum     = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, mul_a_r} : '0);
  assign mul_sq      = {mul_hi_r[SAMPLE_BITS-2:0], mul_lo_r[MB-1 -: SAMPLE_BITS]};
  assign mul_scaled  = {mul_hi_r[MS_BITS-2:0], mul_lo_r[MB-1]};
  assign mul_inexact = |mul_lo_r[MB-2 -: COEF_FRAC];

  assign sqrt_rem_ext = {rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign sqrt_trial   = {1'b0, root_r, 2'b01};
  assign sqrt_ge      = (sqrt_rem_ext >= sqrt_trial);
  assign sqrt_diff    = sqrt_rem_ext - sqrt_trial;
  assign sqrt_root    = {root_r[SAMPLE_BITS-2:0], sqrt_ge};

  assign sq_above = (sq_r > ms_r);
  assign ms_diff  = sq_above ? (sq_r - ms_r) : (ms_r - sq_r);
  assign ms_coef  = sq_above ? sat_coef(rac_r) : sat_coef(rrc_r);
  assign ms_upd   = rise_r ? (ms_r + mul_scaled)
                           : (ms_r - mul_scaled - MS_BITS'(mul_inexact));

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.peak            = out_peak_r;
  assign out_ch.peak_hold_level = out_hold_r;
  assign out_ch.rms_level       = out_rms_r;

  always_comb begin
    state_nxt        = state_r;
    hold_samples_nxt = hold_samples_r;
    prc_nxt          = prc_r;
    rrc_nxt          = rrc_r;
    rac_nxt          = rac_r;
    peak_max_nxt     = peak_max_r;
    held_nxt         = held_r;
    hold_cnt_nxt     = hold_cnt_r;
    ms_nxt           = ms_r;
    rms_nxt          = rms_r;
    decay_nxt        = decay_r;
    out_valid_nxt    = out_valid_r & ~out_ch.ready;
    mag_nxt          = mag_r;
    sq_nxt           = sq_r;
    rise_nxt         = rise_r;
    mul_a_nxt        = mul_a_r;
    mul_hi_nxt       = mul_hi_r;
    mul_lo_nxt       = mul_lo_r;
    cnt_nxt          = cnt_r;
    rad_nxt          = rad_r;
    rem_nxt          = rem_r;
    root_nxt         = root_r;
    out_peak_nxt     = out_peak_r;
    out_hold_nxt     = out_hold_r;
    out_rms_nxt      = out_rms_r;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HOLD_SAMPLES:      hold_samples_nxt = cfg_wdata[HOLD_CFG_BITS-1:0];
        REG_PEAK_RELEASE_COEF: prc_nxt = cfg_wdata[COEF_BITS-1:0];
        REG_RMS_RELEASE_COEF:  rrc_nxt = cfg_wdata[COEF_BITS-1:0];
        REG_RMS_ATTACK_COEF:   rac_nxt = cfg_wdata[COEF_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (kind_t'(in_ch.kind))
            KIND_SAMPLE: begin
              mag_nxt    = in_mag;
              mul_a_nxt  = MS_BITS'(in_mag);
              mul_hi_nxt = '0;
              mul_lo_nxt = MB'(in_mag);
              cnt_nxt    = CNT_BITS'(SAMPLE_BITS);
              state_nxt  = S_SQ;
            end
            KIND_CLR_PEAK: begin
              peak_max_nxt = '0;
              state_nxt    = S_EMIT;
            end
            KIND_CLR_ALL: begin
              peak_max_nxt = '0;
              held_nxt     = '0;
              hold_cnt_nxt = '0;
              ms_nxt       = '0;
              rms_nxt      = '0;
              state_nxt    = S_EMIT;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SQ, S_DECAY, S_MS: begin
        mul_hi_nxt = mul_sum[MS_BITS:1];
        mul_lo_nxt = {mul_sum[0], mul_lo_r[MB-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          unique case (state_r)
            S_SQ:    state_nxt = S_SQ_END;
            S_DECAY: state_nxt = S_MS_SET;
            default: state_nxt = S_MS_END;
          endcase
        end
      end
      S_SQ_END: begin
        sq_nxt    = mul_sq;
        state_nxt = S_MS_SET;
        if (mag_r > peak_max_r) begin
          peak_max_nxt = mag_r;
        end
        if (mag_r > held_r) begin
          held_nxt     = mag_r;
          hold_cnt_nxt = HOLD_BITS'(hold_samples_r);
        end else if (hold_cnt_r != '0) begin
          hold_cnt_nxt = hold_cnt_r - 1'b1;
        end else begin
          decay_nxt  = 1'b1;
          mul_a_nxt  = MS_BITS'(held_r);
          mul_hi_nxt = '0;
          mul_lo_nxt = MB'(COEF_ONE - sat_coef(prc_r));
          cnt_nxt    = CNT_BITS'(COEF_BITS);
          state_nxt  = S_DECAY;
        end
      end
      S_MS_SET: begin
        if (decay_r) begin
          held_nxt  = mul_scaled[SAMPLE_BITS-1:0];
          decay_nxt = 1'b0;
        end
        rise_nxt   = sq_above;
        mul_a_nxt  = ms_diff;
        mul_hi_nxt = '0;
        mul_lo_nxt = MB'(ms_coef);
        cnt_nxt    = CNT_BITS'(COEF_BITS);
        state_nxt  = S_MS;
      end
      S_MS_END: begin
        ms_nxt    = ms_upd;
        rad_nxt   = {1'b0, ms_upd};
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_BITS'(SAMPLE_BITS);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        rem_nxt  = sqrt_ge ? sqrt_diff[SAMPLE_BITS:0] : sqrt_rem_ext[SAMPLE_BITS:0];
        root_nxt = sqrt_root;
        rad_nxt  = {rad_r[RAD_BITS-3:0], 2'b00};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          rms_nxt   = sqrt_root;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_peak_nxt  = peak_max_r;
          out_hold_nxt  = held_r;
          out_rms_nxt   = rms_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      hold_samples_r <= HOLD_SAMPLES_RST;
      prc_r          <= PEAK_RELEASE_COEF_RST;
      rrc_r          <= RMS_RELEASE_COEF_RST;
      rac_r          <= RMS_ATTACK_COEF_RST;
      peak_max_r     <= '0;
      held_r         <= '0;
      hold_cnt_r     <= '0;
      ms_r           <= '0;
      rms_r          <= '0;
      decay_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      hold_samples_r <= hold_samples_nxt;
      prc_r          <= prc_nxt;
      rrc_r          <= rrc_nxt;
      rac_r          <= rac_nxt;
      peak_max_r     <= peak_max_nxt;
      held_r         <= held_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
      ms_r           <= ms_nxt;
      rms_r          <= rms_nxt;
      decay_r        <= decay_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    rise_r     <= rise_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_hi_r   <= mul_hi_nxt;
    mul_lo_r   <= mul_lo_nxt;
    cnt_r      <= cnt_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_peak_r <= out_peak_nxt;
    out_hold_r <= out_hold_nxt;
    out_rms_r  <= out_rms_nxt;
  end

endmodule

[hdl/rphm_checker.sv]
// ----------------------------------------------------------------------------
// rphm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module rphm_checker #(
  parameter int SAMPLE_BITS = rphm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_peak,
  input logic [SAMPLE_BITS-1:0] out_hold,
  input logic [SAMPLE_BITS-1:0] out_rms
);
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peak) && $stable(out_hold)
                                && $stable(out_rms))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in progress");

  a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak <= FULL_SCALE && out_hold <= FULL_SCALE
                  && out_rms <= FULL_SCALE)
    else $error("level above full scale");

  a_no_result_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid || !$past(in_ready))
    else $error("result beat from an idle block");

endmodule

bind rms_peak_hold_meter_core rphm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_rphm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_peak  (out_ch.peak),
  .out_hold  (out_ch.peak_hold_level),
  .out_rms   (out_ch.rms_level)
);

[tb/rms_peak_hold_meter_core_tb.sv]
// ----------------------------------------------------------------------------
// rms_peak_hold_meter_core_tb
// Self-checking bench for the RMS and peak-hold level meter. A directed table
// covers sample extremes, the clear kinds, the unused kind and out-of-range
// register values. It is followed by randomized phases, one per register
// setting, with loud, quiet and silent stretches. Every result beat is
// checked against the row's expected levels where a row gives them, else
// against a bit-exact level predictor stepped on each accepted input beat.
// ----------------------------------------------------------------------------
module rms_peak_hold_meter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rphm_pkg::*;

  localparam int SB              = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 120;
  localparam int N_PHASES        = 8;
  localparam int PHASE_BEATS     = 240;
  localparam int MAX_REPORTS     = 10;
  localparam int TIMEOUT_NS      = 3_000_000;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam logic [COEF_BITS-1:0] COEF_ONE    = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [63:0]          MS_MASK     = (64'd1 << (2 * SB - 1)) - 64'd1;

  typedef struct packed {
    logic [SB-1:0] peak;
    logic [SB-1:0] hold;
    logic [SB-1:0] rms;
  } levels_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_act_t;

  typedef struct packed {
    row_act_t                 act;
    logic [1:0]               sel;
    logic [CFG_DATA_BITS-1:0] data;
    logic                     typed;
    levels_t                  want;
  } dir_row_t;

  localparam int N_DIR = 27;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_BEAT, KIND_SAMPLE,   25'h0000000, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_UNUSED,   25'h05A5A5A, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_CLR_ALL,  25'h0000000, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_CLR_PEAK, 25'h0FFFFFF, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0800000, 1'b0, '0},
    '{ROW_BEAT, KIND_SAMPLE,   25'h07FFFFF, 1'b0, '0},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0FFFFFF, 1'b0, '0},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0000001, 1'b0, '0},
    '{ROW_BEAT, KIND_CLR_PEAK, 25'h0000000, 1'b0, '0},
    '{ROW_BEAT, KIND_UNUSED,   25'h0A5A5A5, 1'b0, '0},
    '{ROW_BEAT, KIND_CLR_ALL,  25'h0000000, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_REG,  REG_HOLD_SAMPLES,      25'h1FFFFFF, 1'b0, '0},
    '{ROW_REG,  REG_PEAK_RELEASE_COEF, 25'h0000000, 1'b0, '0},
    '{ROW_REG,  REG_RMS_RELEASE_COEF,  25'h1000000, 1'b0, '0},
    '{ROW_REG,  REG_RMS_ATTACK_COEF,   25'h1FFFFFF, 1'b0, '0},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0800000, 1'b1, '{24'h800000, 24'h800000, 24'h800000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h07FFFFF, 1'b1, '{24'h800000, 24'h800000, 24'h7FFFFF}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0000001, 1'b1, '{24'h800000, 24'h800000, 24'h000001}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0000000, 1'b1, '{24'h800000, 24'h800000, 24'h000000}},
    '{ROW_BEAT, KIND_CLR_PEAK, 25'h0000000, 1'b1, '{24'h000000, 24'h800000, 24'h000000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0FFFFFF, 1'b1, '{24'h000001, 24'h800000, 24'h000001}},
    '{ROW_REG,  REG_HOLD_SAMPLES,      25'h0000000, 1'b0, '0},
    '{ROW_REG,  REG_PEAK_RELEASE_COEF, 25'h1000000, 1'b0, '0},
    '{ROW_BEAT, KIND_CLR_ALL,  25'h0000000, 1'b1, '{24'h000000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0400000, 1'b1, '{24'h400000, 24'h400000, 24'h400000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0000000, 1'b1, '{24'h400000, 24'h000000, 24'h000000}},
    '{ROW_BEAT, KIND_SAMPLE,   25'h0123456, 1'b0, '0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  rphm_in_if  #(.SAMPLE_BITS(SB)) in_ch  ();
  rphm_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  rms_peak_hold_meter_core #(
    .SAMPLE_BITS (SB),
    .HOLD_BITS   (HOLD_BITS_DEF)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and meter state
  logic [HOLD_CFG_BITS-1:0] set_hold     = HOLD_SAMPLES_RST;
  logic [COEF_BITS-1:0]     set_peak_rel = PEAK_RELEASE_COEF_RST;
  logic [COEF_BITS-1:0]     set_rms_rel  = RMS_RELEASE_COEF_RST;
  logic [COEF_BITS-1:0]     set_rms_att  = RMS_ATTACK_COEF_RST;

  logic [SB-1:0]            meter_peak      = '0;
  logic [SB-1:0]            meter_held      = '0;
  logic [HOLD_BITS_DEF-1:0] meter_hold_left = '0;
  logic [63:0]              meter_ms        = '0;

  levels_t levels_due [$];
  levels_t seen_levels;
  levels_t want_levels;
  int      level_errors = 0;
  int      burst_left   = 0;

  function automatic logic [COEF_BITS-1:0] clamp_coef(input logic [COEF_BITS-1:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

  function automatic logic [63:0] scale_q24(input logic [63:0] mag,
                                            input logic [COEF_BITS-1:0] c,
                                            output bit inexact);
    logic [88:0] prod;
    prod    = {25'd0, mag} * {64'd0, c};
    inexact = |prod[COEF_FRAC-1:0];
    return prod[87:COEF_FRAC];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic levels_t meter_step(input logic [KIND_BITS-1:0] k,
                                         input logic [SB-1:0] smp);
    logic [SB:0] mag;
    logic [63:0] sq;
    logic [63:0] stp;
    bit          inexact;
    levels_t     lv;
    case (k)
      KIND_SAMPLE: begin
        mag = smp[SB-1] ? (~{1'b1, smp} + 1'b1) : {1'b0, smp};
        sq  = 64'(mag) * 64'(mag);
        if (mag > meter_peak) meter_peak = mag[SB-1:0];
        if (mag > meter_held) begin
          meter_held      = mag[SB-1:0];
          meter_hold_left = set_hold;
        end else if (meter_hold_left != 0) begin
          meter_hold_left = meter_hold_left - 1'b1;
        end else begin
          meter_held = SB'(scale_q24(64'(meter_held), COEF_ONE - clamp_coef(set_peak_rel),
                                     inexact));
        end
        if (sq > meter_ms) begin
          meter_ms = meter_ms + scale_q24(sq - meter_ms, clamp_coef(set_rms_att), inexact);
        end else begin
          stp = scale_q24(meter_ms - sq, clamp_coef(set_rms_rel), inexact);
          if (inexact) stp = stp + 1;
          meter_ms = (stp > meter_ms) ? 64'd0 : meter_ms - stp;
        end
        meter_ms = meter_ms & MS_MASK;
      end
      KIND_CLR_PEAK: meter_peak = '0;
      KIND_CLR_ALL: begin
        meter_peak      = '0;
        meter_held      = '0;
        meter_hold_left = '0;
        meter_ms        = '0;
      end
      default: ;
    endcase
    lv.peak = meter_peak;
    lv.hold = meter_held;
    lv.rms  = SB'(floor_sqrt(meter_ms));
    return lv;
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return COEF_BITS'($urandom_range(0, 4095));
      1: return COEF_BITS'($urandom_range(0, 1 << 20));
      2: return COEF_BITS'($urandom_range(0, 1 << 24));
      default: return COEF_BITS'($urandom_range(1 << 24, (1 << 25) - 1));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_HOLD_SAMPLES:      set_hold     = data[HOLD_CFG_BITS-1:0];
      REG_PEAK_RELEASE_COEF: set_peak_rel = data;
      REG_RMS_RELEASE_COEF:  set_rms_rel  = data;
      REG_RMS_ATTACK_COEF:   set_rms_att  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every level beat has come back
  task automatic wait_idle(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_beat(input logic [KIND_BITS-1:0] k, input logic [SB-1:0] smp,
                           input logic typed, input levels_t want);
    int      gap;
    levels_t got;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= k;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    got = meter_step(k, smp);
    levels_due.push_back(typed ? want : got);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("rms_peak_hold_meter_core test failed");
    $finish;
  end

  // receiver stall pattern: free running, random, or long stalls
  initial begin
    int  mode;
    int  seg;
    int  stall;
    logic rdy;
    mode  = 0;
    seg   = 0;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seg == 0) begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(50, 500);
      end
      seg--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 9) < 7);
        default: begin
          if (stall > 0) begin
            stall--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 7) == 0) stall = $urandom_range(1, 25);
          end
        end
      endcase
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_levels = '{out_ch.peak, out_ch.peak_hold_level, out_ch.rms_level};
      if (levels_due.size() == 0) begin
        if (level_errors < MAX_REPORTS)
          $display("%0t: level beat with none due: peak %h hold %h rms %h",
                   $realtime, seen_levels.peak, seen_levels.hold, seen_levels.rms);
        level_errors++;
      end else begin
        want_levels = levels_due.pop_front();
        if (want_levels.peak !== seen_levels.peak || want_levels.hold !== seen_levels.hold
            || want_levels.rms !== seen_levels.rms) begin
          if (level_errors < MAX_REPORTS)
            $display("%0t: level mismatch: peak %h/%h hold %h/%h rms %h/%h (exp/got)",
                     $realtime, want_levels.peak, seen_levels.peak, want_levels.hold,
                     seen_levels.hold, want_levels.rms, seen_levels.rms);
          level_errors++;
        end
      end
    end
  end

  initial begin
    logic [COEF_BITS-1:0]     regs [4];
    logic [KIND_BITS-1:0]     k;
    logic [SB-1:0]            smp;
    logic signed [SB-1:0]     raw;
    int                       beats;
    int                       seg_left;
    int                       amp_shift;
    int                       pick;
    bit                       quiet;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = '0;
    in_ch.sample = '0;
    seg_left     = 0;
    amp_shift    = 0;
    quiet        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].act == ROW_REG) begin
        wait_idle(SETTLE_CYCLES);
        write_reg(cfg_reg_t'(DIR_ROWS[i].sel), DIR_ROWS[i].data);
      end else begin
        send_beat(DIR_ROWS[i].sel, DIR_ROWS[i].data[SB-1:0], DIR_ROWS[i].typed,
                  DIR_ROWS[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle(SETTLE_CYCLES);
      case (ph)
        0: regs = '{25'd5, 25'h0100000, 25'h0100000, 25'h0400000};
        1: regs = '{25'd0, 25'h1000000, 25'h0000000, 25'h0000000};
        2: regs = '{25'h1FFFFFF, 25'h0000000, 25'h1FFFFFF, 25'h1FFFFFF};
        3: regs = '{25'd1, 25'h1FFFFFF, 25'd1522, 25'd30403};
        4: regs = '{25'd20, 25'd1522, 25'd3043, 25'd30403};
        5: regs = '{25'(HOLD_SAMPLES_RST), PEAK_RELEASE_COEF_RST, RMS_RELEASE_COEF_RST,
                    RMS_ATTACK_COEF_RST};
        default: regs = '{25'($urandom_range(0, 64)), rand_coef(), rand_coef(), rand_coef()};
      endcase
      for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), regs[r]);

      beats = 0;
      while (beats < PHASE_BEATS) begin
        if (seg_left == 0) begin
          seg_left  = $urandom_range(1, 40);
          amp_shift = $urandom_range(0, SB - 1);
          quiet     = ($urandom_range(0, 4) == 0);
        end
        seg_left--;
        pick = $urandom_range(0, 99);
        if (pick < 3)      k = KIND_CLR_PEAK;
        else if (pick < 5) k = KIND_CLR_ALL;
        else if (pick < 7) k = KIND_UNUSED;
        else               k = KIND_SAMPLE;
        if (k != KIND_SAMPLE) begin
          smp = SB'($urandom);
        end else if (quiet) begin
          smp = '0;
        end else if ($urandom_range(0, 99) == 0) begin
          smp = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
        end else begin
          raw = SB'($urandom);
          smp = raw >>> amp_shift;
        end
        send_beat(k, smp, 1'b0, '0);
        if (k != KIND_UNUSED) beats++;
        if ($urandom_range(0, 199) == 0) wait_idle(0);
      end
    end

    wait_idle(DRAIN_CYCLES);
    if (level_errors == 0)
      $display("rms_peak_hold_meter_core test passed");
    else
      $display("rms_peak_hold_meter_core test failed");
    $finish;
  end

endmodule
